FILE: rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants for the UTF-8 decoder
// Holds the code point width, the result queue sizing and the structs that
// carry decoded results from the decode stage to the result queue.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned CP_W       = 21;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CP_BYTES_W = 24;

  // Code point emitted on malformed input until software writes another one.
  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

  // Result queue: four entries, so two results can be pushed while one waits.
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  // One queued result.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } u8dec_entry_t;

  // Results of one decoded item: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0]      count;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
  } u8dec_push_t;

endpackage

FILE: rtl/core/utf8_lenient_decoder.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder: lenient UTF-8 to code point decoder
// Top level: input register and decode stage feeding a small result queue.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one byte per transaction in s_tdata; s_tlast
//   marks end of string (the byte is then ignored), which flushes a broken
//   pending sequence as a replacement code and clears the decoder state.
//   The output stream carries one code point per transaction in m_tdata;
//   m_tlast is set on the final result caused by an input transaction.
//   An input transaction yields zero, one or two results.
//   The cfg channel writes the replacement code (reset value 0xFFFD); it is
//   always ready; the user must write it only while the block is idle, as
//   the block itself does not enforce it. The input byte is registered in the
//   decode stage, and its results are registered in the result queue.
//   One byte is taken every cycle while the queue has room for its results;
//   items with two results are absorbed by the four-entry result queue,
//   and the output gives one result per cycle while the receiver is ready.
//   When the receiver stalls, the queue fills and s_tready drops once it
//   lacks room for the next item's results; nothing is lost or repeated.
//   Synchronous reset empties the queue and clears the decoder state.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data   // [20:0] replacement_code
);
  import u8dec_pkg::*;

  u8dec_push_t push;
  logic [2:0]  q_free;

  u8dec_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_free   (q_free),
    .push     (push)
  );

  u8dec_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_free  (q_free),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

FILE: rtl/core/u8dec_decode.sv
// ----------------------------------------------------------------------------
// u8dec_decode: input register and single-pass byte decode
// Registers one input transaction, classifies the byte, updates the owed
// trail count and the partial code point, and pushes up to two results.
// ----------------------------------------------------------------------------
module u8dec_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] byte_in
  input  logic                     s_tlast,   // end_of_string
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [20:0]              cfg_data,  // [20:0] replacement_code
  input  logic [2:0]               q_free,
  output u8dec_pkg::u8dec_push_t   push
);
  import u8dec_pkg::*;

  logic              in_vld;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eos;
  logic [1:0]        owed;
  logic [1:0]        owed_next;
  logic [CP_W-1:0]   partial;
  logic [CP_W-1:0]   partial_next;
  logic [CP_W-1:0]   repl;
  logic              adv;
  u8dec_push_t       res;

  // Place a payload at the given six-bit trail position.
  function automatic logic [CP_W-1:0] place(input logic [6:0] v, input logic [1:0] pos);
    logic [CP_W-1:0] r;
    r = '0;
    case (pos)
      2'd0: r = {14'd0, v};
      2'd1: r = {8'd0, v, 6'd0};
      2'd2: r = {2'd0, v, 12'd0};
      default: r = {v[2:0], 18'd0};
    endcase
    return r;
  endfunction

  // Decode of the registered byte against the current state.
  always_comb begin
    logic       first_err;
    logic [1:0] lead_owed;
    logic [6:0] payload;
    logic       forbidden;
    logic [CP_W-1:0] emit;
    logic       do_emit;
    res          = '0;
    res.cp0      = repl;
    res.cp1      = repl;
    owed_next    = owed;
    partial_next = partial;
    first_err    = (owed != 2'd0);
    lead_owed    = 2'd0;
    payload      = '0;
    forbidden    = 1'b0;
    emit         = repl;
    do_emit      = 1'b0;
    if (in_eos) begin
      res.count    = first_err ? 2'd1 : 2'd0;
      owed_next    = 2'd0;
      partial_next = '0;
    end else if (in_byte[7:6] == 2'b10) begin
      // Continuation byte: fill six more bits, or flag a stray one.
      if (first_err) begin
        owed_next    = owed - 2'd1;
        partial_next = partial | place({1'b0, in_byte[5:0]}, owed_next);
        if (owed_next == 2'd0) begin
          res.count = 2'd1;
          res.cp0   = partial_next;
        end
      end else begin
        res.count = 2'd1;
      end
    end else begin
      // ASCII, lead or forbidden byte; a pending sequence is reported as broken first.
      if (!in_byte[7]) begin
        lead_owed = 2'd0;
        payload   = in_byte[6:0];
      end else if (!in_byte[5]) begin
        lead_owed = 2'd1;
        payload   = {2'd0, in_byte[4:0]};
      end else if (!in_byte[4]) begin
        lead_owed = 2'd2;
        payload   = {3'd0, in_byte[3:0]};
      end else if (!in_byte[3]) begin
        lead_owed = 2'd3;
        payload   = {4'd0, in_byte[2:0]};
      end else begin
        forbidden = 1'b1;
      end
      owed_next = lead_owed;
      if (forbidden) begin
        partial_next = repl;
        emit         = repl;
        do_emit      = 1'b1;
      end else begin
        partial_next = place(payload, lead_owed);
        emit         = partial_next;
        do_emit      = (lead_owed == 2'd0);
      end
      if (first_err) begin
        res.count = do_emit ? 2'd2 : 2'd1;
        res.cp1   = emit;
      end else begin
        res.count = do_emit ? 2'd1 : 2'd0;
        res.cp0   = emit;
      end
    end
  end

  // The item leaves the input register once the queue has room for its results.
  assign adv      = in_vld && ({1'b0, res.count} <= q_free);
  assign s_tready = !in_vld || adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    push = res;
    if (!adv) begin
      push.count = 2'd0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
    end
  end

  // Decoder state and the replacement code register.
  always_ff @(posedge clk) begin
    if (rst) begin
      owed    <= 2'd0;
      partial <= '0;
      repl    <= REPL_RESET;
    end else begin
      if (adv) begin
        owed    <= owed_next;
        partial <= partial_next;
      end
      if (cfg_valid) begin
        repl <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/core/u8dec_out_fifo.sv
// ----------------------------------------------------------------------------
// u8dec_out_fifo: result queue
// Four-entry queue that takes up to two results a cycle from the decode
// stage and presents one result a cycle on the output stream.
// ----------------------------------------------------------------------------
module u8dec_out_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  u8dec_pkg::u8dec_push_t   push,
  output logic [2:0]               q_free,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [23:0]              m_tdata,   // [20:0] code_point, [23:21] zero
  output logic                     m_tlast    // last_of_run
);
  import u8dec_pkg::*;

  u8dec_entry_t      mem [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] cnt;
  logic              pop;
  u8dec_entry_t      e0;
  u8dec_entry_t      e1;

  assign pop      = m_tvalid && m_tready;
  assign q_free   = QCNT_W'(QDEPTH) - cnt;
  assign m_tvalid = (cnt != '0);
  assign m_tdata  = {{(CP_BYTES_W - CP_W){1'b0}}, mem[head].cp};
  assign m_tlast  = mem[head].last;

  assign e0 = '{cp: push.cp0, last: (push.count == 2'd1)};
  assign e1 = '{cp: push.cp1, last: 1'b1};

  // Entry writes; a pair lands in two neighboring slots.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[tail] <= e0;
    end
    if (push.count == 2'd2) begin
      mem[tail + QPTR_W'(1)] <= e1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      tail <= tail + push.count;
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      cnt <= cnt + {1'b0, push.count} - {2'b0, pop};
    end
  end

endmodule

FILE: tb/sv/utf8_lenient_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_tb: self-checking testbench for the UTF-8 decoder
// Feeds directed and random byte strings through the input stream, and
// checks every code point against typed-in results or a cycle-free model.
// The replacement code is changed between phases. Both stream sides idle at
// random, and one long receiver stall fills the block and stalls its input.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder_tb;
  import u8dec_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_BYTES   = 200;  // per replacement setting
  localparam int N_SETTINGS   = 4;
  localparam int LONG_HOLD    = 120;
  localparam int HOLD_BURST   = 60;

  // One directed row: a byte or end mark, optionally with typed-in results.
  typedef struct {
    logic [7:0]      b;
    logic            eos;
    bit              typed;
    int              n;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [CP_BYTES_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CP_W-1:0]       cfg_data = '0;

  // Decoder model state and its replacement code.
  logic [1:0]      owed_q;
  logic [CP_W-1:0] partial_q;
  logic [CP_W-1:0] repl_q;
  logic [CP_W-1:0] decoded_pts [0:1];
  int              n_decoded;

  // Code points still to come out of the block, oldest first.
  u8dec_entry_t pending_pts[$];
  stim_row_t    dir_tab[$];

  int errors = 0;
  int bytes_sent = 0;
  int points_seen = 0;
  int cycles = 0;
  int burst_left = 0;
  int b2b_left = 0;
  int hold_asks = 0;

  utf8_lenient_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock: period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void flag_mismatch(string msg);
    if (errors < MAX_REPORTS) begin
      $display("[%0d] mismatch: %s", cycles, msg);
    end
    errors++;
  endfunction

  function automatic void emit(logic [CP_W-1:0] cp);
    decoded_pts[n_decoded] = cp;
    n_decoded++;
  endfunction

  // Decoder model: updates the state for one item, leaves its code points
  // in decoded_pts.
  function automatic void decode_byte(logic [7:0] b, logic eos);
    logic [1:0]      lead_owed;
    logic [CP_W-1:0] payload;
    n_decoded = 0;
    if (eos) begin
      // End of string flushes a broken sequence and clears the state.
      if (owed_q != 2'd0) emit(repl_q);
      owed_q    = 2'd0;
      partial_q = '0;
    end else if (b[7:6] == 2'b10) begin
      // Continuation: fills the next six bits, or is stray when idle.
      if (owed_q != 2'd0) begin
        owed_q    = owed_q - 2'd1;
        partial_q = partial_q | (CP_W'(b[5:0]) << (owed_q * 6));
        if (owed_q == 2'd0) emit(partial_q);
      end else begin
        emit(repl_q);
      end
    end else begin
      // A lead or ASCII byte cuts off any sequence still owed bytes.
      if (owed_q != 2'd0) emit(repl_q);
      if (b[7:3] == 5'b11111) begin
        owed_q    = 2'd0;
        partial_q = repl_q;
        emit(repl_q);
      end else begin
        if (!b[7]) begin
          lead_owed = 2'd0;
          payload   = CP_W'(b[6:0]);
        end else if (!b[5]) begin
          lead_owed = 2'd1;
          payload   = CP_W'(b[4:0]);
        end else if (!b[4]) begin
          lead_owed = 2'd2;
          payload   = CP_W'(b[3:0]);
        end else begin
          lead_owed = 2'd3;
          payload   = CP_W'(b[2:0]);
        end
        owed_q    = lead_owed;
        partial_q = payload << (lead_owed * 6);
        if (lead_owed == 2'd0) emit(partial_q);
      end
    end
  endfunction

  function automatic void row(logic [7:0] b, logic eos, bit typed = 1'b0, int n = 0,
                              logic [CP_W-1:0] cp0 = '0, logic [CP_W-1:0] cp1 = '0);
    stim_row_t r;
    r.b     = b;
    r.eos   = eos;
    r.typed = typed;
    r.n     = n;
    r.cp0   = cp0;
    r.cp1   = cp1;
    dir_tab = {dir_tab, r};
  endfunction

  // Sends one byte or end mark in bursts with random gaps, then records the
  // code points it must produce.
  task automatic send_byte(logic [7:0] b, logic eos, bit typed = 1'b0, int tn = 0,
                           logic [CP_W-1:0] t0 = '0, logic [CP_W-1:0] t1 = '0);
    int           gap;
    u8dec_entry_t e;
    if (b2b_left > 0) begin
      b2b_left--;
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end else begin
      burst_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    bytes_sent++;
    decode_byte(b, eos);
    if (typed) begin
      for (int i = 0; i < tn; i++) begin
        e.cp   = (i == 0) ? t0 : t1;
        e.last = (i == tn - 1);
        pending_pts = {pending_pts, e};
      end
    end else begin
      for (int i = 0; i < n_decoded; i++) begin
        e.cp   = decoded_pts[i];
        e.last = (i == n_decoded - 1);
        pending_pts = {pending_pts, e};
      end
    end
  endtask

  // Stops sending and waits until the block has nothing left in flight.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_replacement(logic [CP_W-1:0] code);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    repl_q = code;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random strings: mostly well-formed sequences with random payload, the
  // rest truncated sequences, stray and forbidden bytes, random bytes and end marks.
  task automatic random_strings(int target);
    int         start;
    int         kind;
    int         len;
    logic [7:0] lead;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      case (len)
        1: lead = {1'b0, 7'($urandom)};
        2: lead = {3'b110, 5'($urandom)};
        3: lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      if (kind < 65) begin
        send_byte(lead, 1'b0);
        for (int i = 1; i < len; i++) send_byte({2'b10, 6'($urandom)}, 1'b0);
      end else if (kind < 73) begin
        send_byte(8'($urandom), 1'b1);
      end else if (kind < 81) begin
        // Lead cut short; the next lead, ASCII byte or end mark breaks it.
        if (len == 1) len = 2;
        lead[7:6] = 2'b11;
        send_byte(lead, 1'b0);
        for (int i = $urandom_range(0, len - 2); i > 0; i--) begin
          send_byte({2'b10, 6'($urandom)}, 1'b0);
        end
      end else if (kind < 89) begin
        send_byte({2'b10, 6'($urandom)}, 1'b0);
      end else if (kind < 95) begin
        send_byte({5'b11111, 3'($urandom)}, 1'b0);
      end else begin
        send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Receiver: a repeating ready pattern, redrawn each time its position wraps,
  // and a long hold-off whenever one is asked for.
  initial begin : receiver
    logic [15:0] stall_pat;
    int          pat_pos;
    int          hold_left;
    int          hold_seen;
    stall_pat = '1;
    pat_pos   = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (pat_pos == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom) | 16'($urandom);
            default: stall_pat = 16'($urandom) & 16'($urandom);
          endcase
          stall_pat[0] = 1'b1;
        end
        m_tready <= stall_pat[pat_pos % 16];
        pat_pos = (pat_pos + 1) % 64;
      end
    end
  end

  // Output checker: each transaction against the oldest expected point.
  always @(posedge clk) begin
    u8dec_entry_t e;
    if (!rst && m_tvalid && m_tready) begin
      points_seen++;
      if (pending_pts.size() == 0) begin
        flag_mismatch($sformatf("unexpected result data=%h last=%b", m_tdata, m_tlast));
      end else begin
        e = pending_pts.pop_front();
        if (m_tdata !== {{(CP_BYTES_W - CP_W){1'b0}}, e.cp} || m_tlast !== e.last) begin
          flag_mismatch($sformatf("expected cp=%h last=%b, got data=%h last=%b",
                                  e.cp, e.last, m_tdata, m_tlast));
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycles, pending_pts.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    logic [CP_W-1:0] settings [0:N_SETTINGS-1];
    owed_q    = 2'd0;
    partial_q = '0;
    repl_q    = REPL_RESET;

    // Directed strings, replacement code at its reset value.
    row(8'h41, 1'b0, 1'b1, 1, 21'h41);
    row(8'h00, 1'b0, 1'b1, 1, 21'h0);
    row(8'h7F, 1'b0, 1'b1, 1, 21'h7F);
    row(8'h80, 1'b0, 1'b1, 1, REPL_RESET);          // stray continuation
    row(8'hF8, 1'b0, 1'b1, 1, REPL_RESET);          // forbidden bytes
    row(8'hFF, 1'b0, 1'b1, 1, REPL_RESET);
    row(8'hC3, 1'b0, 1'b1, 0);                      // two-byte form
    row(8'hA9, 1'b0);
    row(8'hED, 1'b0, 1'b1, 0);                      // surrogate passes through
    row(8'hA0, 1'b0);
    row(8'h80, 1'b0);
    row(8'hF7, 1'b0, 1'b1, 0);                      // largest four-byte point
    row(8'hBF, 1'b0);
    row(8'hBF, 1'b0);
    row(8'hBF, 1'b0, 1'b1, 1, 21'h1FFFFF);
    row(8'hC2, 1'b0, 1'b1, 0);                      // ASCII cuts off a lead
    row(8'h41, 1'b0, 1'b1, 2, REPL_RESET, 21'h41);
    row(8'hE1, 1'b0);                               // new lead cuts off a lead
    row(8'hC2, 1'b0, 1'b1, 1, REPL_RESET);
    row(8'hFF, 1'b0, 1'b1, 2, REPL_RESET, REPL_RESET);
    row(8'hE0, 1'b0);                               // string ends mid-sequence
    row(8'h00, 1'b1, 1'b1, 1, REPL_RESET);
    row(8'hFF, 1'b1, 1'b1, 0);                      // end mark while idle

    settings[0] = '0;
    settings[1] = '1;
    settings[2] = CP_W'($urandom_range(0, 21'h1FFFFF));
    settings[3] = REPL_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].eos, dir_tab[i].typed,
                dir_tab[i].n, dir_tab[i].cp0, dir_tab[i].cp1);
    end
    drain();

    for (int s = 0; s < N_SETTINGS; s++) begin
      write_replacement(settings[s]);
      // One phase starts with a long receiver stall under a steady input.
      if (s == 1) begin
        hold_asks++;
        b2b_left = HOLD_BURST;
      end
      random_strings(RAND_BYTES);
      drain();
    end

    if (pending_pts.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_pts.size()));
    end
    $display("Sent %0d bytes and end marks, checked %0d code points, %0d replacement codes.",
             bytes_sent, points_seen, N_SETTINGS + 1);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_decode.sv
rtl/core/u8dec_out_fifo.sv
rtl/core/utf8_lenient_decoder.sv
tb/sv/utf8_lenient_decoder_tb.sv
